@@ rtl/rdv_pkg.sv @@
`timescale 1ns / 1ps

package rdv_pkg;

    // Dump length limit per request
    localparam int MAX_RESULTS = 32;
    localparam int KW          = $clog2(MAX_RESULTS + 1);

    localparam logic [4:0] INF_METRIC   = 5'd16;
    localparam logic [7:0] CMD_REQUEST  = 8'd1;
    localparam logic [7:0] CMD_RESPONSE = 8'd2;
    localparam logic [7:0] RIP_VERSION  = 8'd2;

    typedef enum logic [1:0] {
        REQ_HEADER,
        REQ_ENTRY,
        REQ_DELETE,
        REQ_ADVERTISE
    } rdv_req_type_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INSERTED,
        ST_UPDATED,
        ST_UNCHANGED,
        ST_FULL,
        ST_CMD_ERR,
        ST_VER_ERR,
        ST_NOT_FOUND
    } rdv_status_t;

    // One route table slot as stored in the RAM
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] nexthop;
        logic [4:0]  metric;
        logic [7:0]  iface;
    } rdv_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic look_start;
        logic look_step;
        logic dump_start;
        logic dump_step;
        logic apply;
        logic remove;
        logic hdr_emit;
        logic dump_fin;
    } rdv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        rdv_req_type_t req_type;
        logic          hdr_dump;
        logic          look_done;
        logic          dump_done;
        logic          out_free;
    } rdv_stat_t;

endpackage

@@ rtl/rdv_req_if.sv @@
`timescale 1ns / 1ps

// Request channel
interface rdv_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  command;
    logic [7:0]  version;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [4:0]  metric;
    logic [31:0] source_addr;
    logic [7:0]  iface;
    logic        entry_last;

    modport source (
        output valid, req_type, command, version, dest, mask, metric,
               source_addr, iface, entry_last,
        input  ready
    );

    modport sink (
        input  valid, req_type, command, version, dest, mask, metric,
               source_addr, iface, entry_last,
        output ready
    );
endinterface

@@ rtl/rdv_rsp_if.sv @@
`timescale 1ns / 1ps

// Result channel
interface rdv_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        route_valid;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic [31:0] route_nexthop;
    logic [4:0]  route_metric;
    logic        last;

    modport source (
        output valid, status, route_valid, route_dest, route_mask, route_nexthop,
               route_metric, last,
        input  ready
    );

    modport sink (
        input  valid, status, route_valid, route_dest, route_mask, route_nexthop,
               route_metric, last,
        output ready
    );
endinterface

@@ rtl/rdv_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module rdv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rdv_ctrl.sv @@
`timescale 1ns / 1ps

// Request sequencer
module rdv_ctrl import rdv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rdv_stat_t stat,
    output rdv_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOK,
        S_APPLY,
        S_REMOVE,
        S_HDR,
        S_DUMP,
        S_DFIN
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req_type)
                    REQ_HEADER:
                    begin
                        if (stat.hdr_dump)
                        begin
                            cmd.dump_start = 1'b1;
                            state_next     = S_DUMP;
                        end
                        else
                        begin
                            state_next = S_HDR;
                        end
                    end
                    REQ_ENTRY, REQ_DELETE:
                    begin
                        cmd.look_start = 1'b1;
                        state_next     = S_LOOK;
                    end
                    REQ_ADVERTISE:
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOOK:
            begin
                cmd.look_step = 1'b1;
                if (stat.look_done)
                begin
                    state_next = (stat.req_type == REQ_ENTRY) ? S_APPLY : S_REMOVE;
                end
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REMOVE:
            begin
                if (stat.out_free)
                begin
                    cmd.remove = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.hdr_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP:
            begin
                cmd.dump_step = 1'b1;
                if (stat.dump_done)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

`ifndef ASSERT_OFF
    // Ready only while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    // An accepted request always goes to dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready_reg) |=> (state_reg == S_DISPATCH && !in_ready_reg))
        else $error("accepted request not dispatched");

    // The apply state is not left while the output register is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && !stat.out_free) |=> (state_reg == S_APPLY))
        else $error("apply left without free output");
`endif

endmodule

@@ rtl/rdv_dpath.sv @@
`timescale 1ns / 1ps

// Route table datapath: request capture, table RAM, scan and result register
module rdv_dpath import rdv_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    rdv_req_if.sink          req,
    rdv_rsp_if.source        rsp,
    input  rdv_cmd_t         cmd,
    output rdv_stat_t        stat
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    // Captured request
    rdv_req_type_t req_type_reg, req_type_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    version_reg, version_next;
    logic [31:0]   dest_reg, dest_next;
    logic [31:0]   mask_reg, mask_next;
    logic [4:0]    metric_reg, metric_next;
    logic [31:0]   src_reg, src_next;
    logic [7:0]    iface_reg, iface_next;

    // Table and scan control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ptr_m1;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    rdv_entry_t    hit_ent_reg, hit_ent_next;
    logic [KW-1:0] k_reg, k_next;
    logic          hold_vld_reg, hold_vld_next;
    rdv_entry_t    hold_ent_reg, hold_ent_next;

    // Result register
    logic          out_vld_reg, out_vld_next;
    rdv_status_t   out_status_reg, out_status_next;
    logic          out_rvalid_reg, out_rvalid_next;
    rdv_entry_t    out_ent_reg, out_ent_next;
    logic          out_last_reg, out_last_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    rdv_entry_t    ram_wdata, ram_rdata;

    // Push into result register
    logic          push;
    rdv_status_t   push_status;
    logic          push_rvalid;
    rdv_entry_t    push_ent;
    logic          push_last;

    logic          match, look_more, look_done, qual, out_free;
    logic          k_full, dump_adv, dump_done, full;
    logic [4:0]    met_sat, nm;
    rdv_status_t   hdr_status;
    logic          hdr_dump;

    rdv_ram #(
        .WIDTH ($bits(rdv_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode of the current scan word and request
    assign match     = rd_vld_reg && (ram_rdata.dest == dest_reg)
                       && (ram_rdata.mask == mask_reg);
    assign look_more = (ptr_reg < count_reg);
    assign look_done = match || (!look_more && !rd_vld_reg);
    assign qual      = rd_vld_reg && (ram_rdata.iface != iface_reg);
    assign out_free  = !out_vld_reg || rsp.ready;
    assign k_full    = (k_reg == KW'(MAX_RESULTS));
    assign dump_adv  = !k_full && (!qual || !hold_vld_reg || out_free);
    assign dump_done = k_full || ((ptr_reg == '0) && !rd_vld_reg);
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign ptr_m1    = ptr_reg - CW'(1);

    // Advertised metric plus one hop, saturated at infinity
    assign met_sat = (metric_reg > INF_METRIC) ? INF_METRIC : metric_reg;
    assign nm      = (met_sat == INF_METRIC) ? INF_METRIC : met_sat + 5'd1;

    assign hdr_dump = (command_reg == CMD_REQUEST) && (version_reg == RIP_VERSION);

    always_comb
    begin
        if ((command_reg != CMD_REQUEST) && (command_reg != CMD_RESPONSE))
        begin
            hdr_status = ST_CMD_ERR;
        end
        else if (version_reg != RIP_VERSION)
        begin
            hdr_status = ST_VER_ERR;
        end
        else
        begin
            hdr_status = ST_OK;
        end
    end

    assign stat.req_type  = req_type_reg;
    assign stat.hdr_dump  = hdr_dump;
    assign stat.look_done = look_done;
    assign stat.dump_done = dump_done;
    assign stat.out_free  = out_free;

    // Command execution
    always_comb
    begin
        req_type_next   = req_type_reg;
        command_next    = command_reg;
        version_next    = version_reg;
        dest_next       = dest_reg;
        mask_next       = mask_reg;
        metric_next     = metric_reg;
        src_next        = src_reg;
        iface_next      = iface_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        k_next          = k_reg;
        hold_vld_next   = hold_vld_reg;
        hold_ent_next   = hold_ent_reg;

        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = '{dest: dest_reg, mask: mask_reg, nexthop: src_reg,
                            metric: nm, iface: iface_reg};
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg[IW-1:0];

        push            = 1'b0;
        push_status     = ST_OK;
        push_rvalid     = 1'b0;
        push_ent        = '0;
        push_last       = 1'b1;

        if (cmd.capture)
        begin
            req_type_next = rdv_req_type_t'(req.req_type);
            command_next  = req.command;
            version_next  = req.version;
            dest_next     = req.dest;
            mask_next     = req.mask;
            metric_next   = req.metric;
            src_next      = req.source_addr;
            iface_next    = req.iface;
        end

        if (cmd.look_start)
        begin
            ptr_next    = '0;
            rd_vld_next = 1'b0;
            hit_next    = 1'b0;
        end

        // Forward search, one read issued per cycle
        if (cmd.look_step)
        begin
            if (look_more)
            begin
                ram_re   = 1'b1;
                ptr_next = ptr_reg + CW'(1);
            end
            rd_vld_next = look_more;
            rd_idx_next = ptr_reg[IW-1:0];
            if (match)
            begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
                hit_ent_next = ram_rdata;
            end
        end

        if (cmd.dump_start)
        begin
            ptr_next      = count_reg;
            rd_vld_next   = 1'b0;
            k_next        = '0;
            hold_vld_next = 1'b0;
        end

        // Backward dump; one route held back so the final one can carry last
        if (cmd.dump_step && dump_adv)
        begin
            if (qual)
            begin
                k_next        = k_reg + KW'(1);
                hold_vld_next = 1'b1;
                hold_ent_next = ram_rdata;
                if (hold_vld_reg)
                begin
                    push        = 1'b1;
                    push_rvalid = 1'b1;
                    push_ent    = hold_ent_reg;
                    push_last   = 1'b0;
                end
            end
            if (ptr_reg != '0)
            begin
                ram_re      = 1'b1;
                ram_raddr   = ptr_m1[IW-1:0];
                ptr_next    = ptr_m1;
                rd_vld_next = 1'b1;
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
        end

        if (cmd.dump_fin)
        begin
            push          = 1'b1;
            push_rvalid   = hold_vld_reg;
            push_ent      = hold_vld_reg ? hold_ent_reg : '0;
            hold_vld_next = 1'b0;
        end

        // Route entry update
        if (cmd.apply)
        begin
            push = 1'b1;
            if (hit_reg)
            begin
                if ((hit_ent_reg.nexthop == src_reg) || (nm < hit_ent_reg.metric))
                begin
                    ram_we      = 1'b1;
                    push_status = ST_UPDATED;
                end
                else
                begin
                    push_status = ST_UNCHANGED;
                end
            end
            else if (nm == INF_METRIC)
            begin
                push_status = ST_UNCHANGED;
            end
            else if (full)
            begin
                push_status = ST_FULL;
            end
            else
            begin
                ram_we      = 1'b1;
                ram_waddr   = count_reg[IW-1:0];
                count_next  = count_reg + CW'(1);
                push_status = ST_INSERTED;
            end
        end

        // Route timeout: mark unreachable
        if (cmd.remove)
        begin
            push = 1'b1;
            if (hit_reg)
            begin
                ram_we      = 1'b1;
                ram_wdata   = '{dest: dest_reg, mask: mask_reg,
                                nexthop: hit_ent_reg.nexthop, metric: INF_METRIC,
                                iface: hit_ent_reg.iface};
                push_status = ST_UPDATED;
            end
            else
            begin
                push_status = ST_NOT_FOUND;
            end
        end

        if (cmd.hdr_emit)
        begin
            push        = 1'b1;
            push_status = hdr_status;
        end
    end

    // Result register load and drain
    always_comb
    begin
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_rvalid_next = out_rvalid_reg;
        out_ent_next    = out_ent_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_vld_next    = 1'b1;
            out_status_next = push_status;
            out_rvalid_next = push_rvalid;
            out_ent_next    = push_ent;
            out_last_next   = push_last;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            k_reg        <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= rd_vld_next;
            hit_reg      <= hit_next;
            k_reg        <= k_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        command_reg    <= command_next;
        version_reg    <= version_next;
        dest_reg       <= dest_next;
        mask_reg       <= mask_next;
        metric_reg     <= metric_next;
        src_reg        <= src_next;
        iface_reg      <= iface_next;
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        hold_ent_reg   <= hold_ent_next;
        out_status_reg <= out_status_next;
        out_rvalid_reg <= out_rvalid_next;
        out_ent_reg    <= out_ent_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.route_valid   = out_rvalid_reg;
    assign rsp.route_dest    = out_ent_reg.dest;
    assign rsp.route_mask    = out_ent_reg.mask;
    assign rsp.route_nexthop = out_ent_reg.nexthop;
    assign rsp.route_metric  = out_ent_reg.metric;
    assign rsp.last          = out_last_reg;

`ifndef ASSERT_OFF
    // Route count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("route count beyond table depth");

    // Dump never exceeds the result limit
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(MAX_RESULTS))
        else $error("dump count beyond limit");

    // A result is only loaded when the register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result overwritten before taken");

    // A write to a fresh slot only happens with room left, and bumps the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !hit_reg) |-> (!full && cmd.apply))
        else $error("insert into full table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !hit_reg) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert without count update");
`endif

endmodule

@@ rtl/rip_distance_vector_route_table_core.sv @@
`timescale 1ns / 1ps

// RIPv2 route table engine. Requests arrive on req, results leave on rsp, each
// a valid/ready channel; the last result of every request carries last = 1.
// One request is handled at a time, and a new one is taken as soon as the
// previous one has placed its final result in the output register. Routes live
// in a single RAM with one read and one write port, and every search and dump
// walks it one slot per cycle, a dump pausing while a held route waits for the
// output register, so that port sets the time per request. A route entry or
// delete search stops at the first slot that matches; a request or periodic
// advertise dump reads the stored routes from the highest slot down, giving up
// to MAX_RESULTS routes. A header that only answers needs no table access. The
// table needs no clearing pass after reset: only slots below the route count
// are read.
module rip_distance_vector_route_table_core import rdv_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rdv_req_if.sink   req,
    rdv_rsp_if.source rsp
);

    rdv_cmd_t  cmd;
    rdv_stat_t stat;
    logic      in_ready;

    assign req.ready = in_ready;

    rdv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdv_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
